/* rtl/core/crp_pkg.sv */
package crp_pkg;

    localparam int PERM_MAX  = 64;
    localparam int RAND_BITS = 16;
    localparam int IDX_W     = $clog2(PERM_MAX);
    localparam int VAL_W     = IDX_W + 1;
    localparam int PROD_W    = RAND_BITS + IDX_W;

    // control of the permutation table ram
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr_a;
        logic [IDX_W-1:0] raddr_b;
    } ram_req_t;

    // one result beat handed to the output register
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] position;
        logic [VAL_W-1:0] value;
        logic             last;
    } out_beat_t;

    function automatic logic [VAL_W-1:0] clamp_size(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = VAL_W'(1);
            end
            else if (v > VAL_W'(PERM_MAX))
            begin
                r = VAL_W'(PERM_MAX);
            end
            return r;
        end
    endfunction

endpackage

/* rtl/core/crp_ram.sv */
module crp_ram (
    input  logic                                 clk,
    input  crp_pkg::ram_req_t                    req,
    output logic [crp_pkg::VAL_W-1:0]            rdata_a,
    output logic [crp_pkg::VAL_W-1:0]            rdata_b
);

    logic [crp_pkg::VAL_W-1:0] mem [crp_pkg::PERM_MAX];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_a <= mem[req.raddr_a];
            rdata_b <= mem[req.raddr_b];
        end
    end

endmodule

/* rtl/core/crp_seq.sv */
module crp_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_kind,
    input  logic [crp_pkg::RAND_BITS-1:0]     in_rand,
    input  logic [crp_pkg::VAL_W-1:0]         perm_size,
    input  logic                              out_free,
    output crp_pkg::out_beat_t                out_beat,
    output crp_pkg::ram_req_t                 ram_req,
    input  logic [crp_pkg::VAL_W-1:0]         rdata_a,
    input  logic [crp_pkg::VAL_W-1:0]         rdata_b
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FILL = 2'd1;
    localparam logic [1:0] S_WR_I = 2'd2;
    localparam logic [1:0] S_WR_J = 2'd3;

    localparam int IW = crp_pkg::IDX_W;
    localparam int VW = crp_pkg::VAL_W;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] step_reg, step_next;
    logic          active_reg, active_next;
    logic [VW-1:0] n_reg, n_next;
    logic [IW-1:0] fill_reg, fill_next;
    logic [VW-1:0] tmp_reg, tmp_next;
    logic [IW-1:0] j_reg, j_next;

    logic [VW-1:0]                 span_full;
    logic [IW-1:0]                 span;
    logic [crp_pkg::PROD_W-1:0]    prod;
    logic [IW-1:0]                 j_pick;
    logic [VW-1:0]                 n_minus1;
    logic                          last_step;
    logic                          accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign n_minus1  = n_reg - VW'(1);
    assign span_full = n_minus1 - {1'b0, step_reg};
    assign span      = span_full[IW-1:0];
    assign prod      = crp_pkg::PROD_W'(in_rand) * crp_pkg::PROD_W'(span);
    assign j_pick    = step_reg + IW'(1) + prod[crp_pkg::PROD_W-1:crp_pkg::RAND_BITS];
    assign last_step = ({1'b0, step_reg} + VW'(1)) >= n_minus1;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        active_next = active_reg;
        n_next      = n_reg;
        fill_next   = fill_reg;
        tmp_next    = tmp_reg;
        j_next      = j_reg;
        ram_req     = '0;
        out_beat    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_kind)
                    begin
                        n_next      = crp_pkg::clamp_size(perm_size);
                        fill_next   = '0;
                        step_next   = '0;
                        active_next = 1'b0;
                        state_next  = S_FILL;
                    end
                    else if (active_reg)
                    begin
                        ram_req.re      = 1'b1;
                        ram_req.raddr_a = step_reg;
                        ram_req.raddr_b = j_pick;
                        j_next          = j_pick;
                        state_next      = S_WR_I;
                    end
                end
            end
            S_FILL:
            begin
                ram_req.waddr = fill_reg;
                ram_req.wdata = {1'b0, fill_reg} + VW'(1);
                if ({1'b0, fill_reg} == n_minus1)
                begin
                    if (n_reg == VW'(1))
                    begin
                        // single element: the start itself gives the result
                        if (out_free)
                        begin
                            ram_req.we        = 1'b1;
                            out_beat.load     = 1'b1;
                            out_beat.position = '0;
                            out_beat.value    = VW'(1);
                            out_beat.last     = 1'b1;
                            state_next        = S_IDLE;
                        end
                    end
                    else
                    begin
                        ram_req.we  = 1'b1;
                        active_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    ram_req.we = 1'b1;
                    fill_next  = fill_reg + IW'(1);
                end
            end
            S_WR_I:
            begin
                if (out_free)
                begin
                    ram_req.we        = 1'b1;
                    ram_req.waddr     = step_reg;
                    ram_req.wdata     = rdata_b;
                    out_beat.load     = 1'b1;
                    out_beat.position = step_reg;
                    out_beat.value    = rdata_b;
                    tmp_next          = rdata_a;
                    state_next        = S_WR_J;
                end
            end
            S_WR_J:
            begin
                ram_req.waddr = j_reg;
                ram_req.wdata = tmp_reg;
                if (!last_step)
                begin
                    ram_req.we = 1'b1;
                    step_next  = step_reg + IW'(1);
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    // on the final step j is n-1, so the old entry i lands there
                    ram_req.we        = 1'b1;
                    out_beat.load     = 1'b1;
                    out_beat.position = n_minus1[IW-1:0];
                    out_beat.value    = tmp_reg;
                    out_beat.last     = 1'b1;
                    step_next         = step_reg + IW'(1);
                    active_next       = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            active_reg <= 1'b0;
            n_reg      <= VW'(1);
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            active_reg <= active_next;
            n_reg      <= n_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg <= tmp_next;
        j_reg   <= j_next;
    end

endmodule

/* rtl/core/cyclic_random_permutation.sv */
// cyclic random permutation generator, one swap per draw beat
// slave stream: tuser = kind (0 start, 1 draw), tdata = rand_value (16 bits)
// master stream: tdata = position, value; tlast marks the final entry
// config: perm_size at address 0 (1..64, 0 counts as 1, above 64 saturates),
// latched when a start beat is taken
// a start beat fills the table ram with 1..n, one entry per cycle; with n = 1
// it waits for a free output stage and emits position 0 value 1 last
// a draw beat reads entries i and j in the same cycle, then writes i back in
// S_WR_I, handing its result on, and j in S_WR_J through the single ram write
// port; the last draw also emits entry n-1 there; beats are taken only in S_IDLE
// draws while no run is active are dropped without result
// a registered output stage holds each result; when the receiver stalls the
// sequencer waits in place, loses no result and takes no new beat meanwhile
// reset: no run active, perm_size 64; table contents stay as they were
module cyclic_random_permutation (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [15:0]                           s_axis_tdata,  // rand_value
    input  logic                                  s_axis_tuser,  // kind
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [15:0]                           m_axis_tdata,  // position, value, zero pad
    output logic                                  m_axis_tlast,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int IW = crp_pkg::IDX_W;
    localparam int VW = crp_pkg::VAL_W;
    localparam logic ADDR_PERM_SIZE = 1'b0;

    logic [VW-1:0]      perm_size_reg;
    logic               out_valid_reg;
    logic [IW-1:0]      out_pos_reg;
    logic [VW-1:0]      out_val_reg;
    logic               out_last_reg;
    logic               out_free;
    crp_pkg::out_beat_t out_beat;
    crp_pkg::ram_req_t  ram_req;
    logic [VW-1:0]      rdata_a;
    logic [VW-1:0]      rdata_b;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_PERM_SIZE) ? {{(32 - VW){1'b0}}, perm_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_size_reg <= VW'(crp_pkg::PERM_MAX);
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_PERM_SIZE))
        begin
            perm_size_reg <= pwdata[VW-1:0];
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= out_beat.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && out_beat.load)
        begin
            out_pos_reg  <= out_beat.position;
            out_val_reg  <= out_beat.value;
            out_last_reg <= out_beat.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - IW - VW){1'b0}}, out_val_reg, out_pos_reg};
    assign m_axis_tlast  = out_last_reg;

    crp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_rand   (s_axis_tdata[crp_pkg::RAND_BITS-1:0]),
        .perm_size (perm_size_reg),
        .out_free  (out_free),
        .out_beat  (out_beat),
        .ram_req   (ram_req),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b)
    );

    crp_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

endmodule

/* tb/sv/crp_tb_pkg.sv */
package crp_tb_pkg;

    // what a slave-side beat asks for, carried on tuser
    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_DRAW  = 1'b1
    } beat_kind_e;

    // register byte addresses
    localparam logic [2:0] REG_PERM_SIZE = 3'd0;
    localparam logic [2:0] REG_UNMAPPED  = 3'd4;

endpackage

/* tb/sv/perm_checker.sv */
module perm_checker
    import crp_pkg::*;
    import crp_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rand_value
    input  logic        s_axis_tuser,   // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // position [5:0], value [12:6], zero pad
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);

    typedef struct packed
    {
        logic [IDX_W-1:0] position;
        logic [VAL_W-1:0] value;
        logic             last;
    } perm_entry_t;

    perm_entry_t      expected_entries[$];
    logic [VAL_W-1:0] shuffle_table [PERM_MAX];
    logic [VAL_W-1:0] size_reg;
    int               run_len;
    int               cursor;
    logic             running;
    int               fail_count;

    // one start or swap step of the shuffle, queueing the entries it finalizes
    task automatic shuffle_step(input logic kind_bit, input logic [15:0] frac);
        int               i;
        int               j;
        logic [31:0]      prod;
        logic [VAL_W-1:0] held;
        if (kind_bit == KIND_START)
        begin
            if (size_reg == '0)
            begin
                run_len = 1;
            end
            else if (size_reg > VAL_W'(PERM_MAX))
            begin
                run_len = PERM_MAX;
            end
            else
            begin
                run_len = int'(size_reg);
            end
            for (int k = 0; k < run_len; k++)
            begin
                shuffle_table[k] = VAL_W'(k + 1);
            end
            cursor = 0;
            running = (run_len > 1);
            if (run_len == 1)
            begin
                expected_entries.push_back('{'0, shuffle_table[0], 1'b1});
            end
        end
        else if (running)
        begin
            i = cursor;
            prod = 32'(frac[RAND_BITS-1:0]) * 32'(run_len - 1 - i);
            j = (i + 1 + int'(prod >> RAND_BITS)) % PERM_MAX;
            held = shuffle_table[i];
            shuffle_table[i] = shuffle_table[j];
            shuffle_table[j] = held;
            expected_entries.push_back('{IDX_W'(i), shuffle_table[i], 1'b0});
            cursor = i + 1;
            if (i + 1 >= run_len - 1)
            begin
                running = 1'b0;
                expected_entries.push_back('{IDX_W'(run_len - 1),
                                             shuffle_table[run_len - 1], 1'b1});
            end
        end
    endtask

    task automatic check_entry(input perm_entry_t got);
        perm_entry_t want;
        if (expected_entries.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("unexpected beat: pos %0d val %0d last %0b",
                         got.position, got.value, got.last);
            end
        end
        else
        begin
            want = expected_entries.pop_front();
            if (got.position !== want.position || got.value !== want.value
                || got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display({"mismatch: expected pos %0d val %0d last %0b, ",
                              "got pos %0d val %0d last %0b"},
                             want.position, want.value, want.last,
                             got.position, got.value, got.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_entries.delete();
            size_reg = VAL_W'(PERM_MAX);
            run_len = 1;
            cursor = 0;
            running = 1'b0;
            fail_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_entry('{m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W+VAL_W-1:IDX_W],
                              m_axis_tlast});
            end
            if (psel && penable && pwrite && pready && paddr == REG_PERM_SIZE)
            begin
                size_reg = pwdata[VAL_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                shuffle_step(s_axis_tuser, s_axis_tdata);
            end
            mismatches <= fail_count;
            pending <= expected_entries.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
module tb;

    import crp_pkg::*;
    import crp_tb_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // rand_value
    logic        s_axis_tuser = 1'b0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // position [5:0], value [12:6], zero pad
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int   mismatches;
    int   pending;
    logic no_gaps = 1'b0;
    int   stall_left = 0;
    int   calm_left = 0;

    cyclic_random_permutation dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    perm_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver pacing: calm stretches, short stalls, now and then a long one
    always @(posedge clk)
    begin : recv_pace
        int roll;
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (calm_left > 0)
        begin
            m_axis_tready <= 1'b1;
            calm_left--;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                m_axis_tready <= 1'b1;
                calm_left = $urandom_range(20, 80);
            end
            else if (roll < 65)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (roll < 95)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] draw_frac();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            return 16'h0000;
        end
        else if (roll == 1)
        begin
            return 16'hffff;
        end
        return 16'($urandom);
    endfunction

    task automatic send_beat(input beat_kind_e kind, input logic [15:0] frac);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= frac;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // let every queued entry come out and the fill of a large start finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        int items_sent;
        int size_raw;
        int run_n;
        int draws;
        int pick;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draw while idle, then a full-size run with extreme fractions
        send_beat(KIND_DRAW, 16'hffff);
        send_beat(KIND_START, 16'hffff);
        send_beat(KIND_DRAW, 16'h0000);
        send_beat(KIND_DRAW, 16'hffff);
        send_beat(KIND_DRAW, 16'h8000);
        send_beat(KIND_DRAW, 16'haaaa);
        send_beat(KIND_DRAW, 16'h5555);
        // restart in the middle of a run
        send_beat(KIND_START, 16'h0000);
        send_beat(KIND_DRAW, 16'h0001);
        drain();

        // size one emits at start, the draw after it is dropped
        reg_write(REG_PERM_SIZE, 32'd1);
        send_beat(KIND_START, 16'h1234);
        send_beat(KIND_DRAW, 16'hffff);
        drain();
        reg_write(REG_PERM_SIZE, 32'd2);
        send_beat(KIND_START, 16'h0000);
        send_beat(KIND_DRAW, 16'hffff);
        send_beat(KIND_DRAW, 16'h0000);
        drain();
        // zero counts as one, oversize saturates
        reg_write(REG_PERM_SIZE, 32'd0);
        send_beat(KIND_START, 16'h0000);
        drain();
        reg_write(REG_PERM_SIZE, 32'd127);
        send_beat(KIND_START, 16'h0000);
        send_beat(KIND_DRAW, 16'hffff);
        send_beat(KIND_DRAW, 16'h7fff);
        drain();
        // write to an unmapped address leaves the size alone
        reg_write(REG_UNMAPPED, 32'd3);
        send_beat(KIND_START, 16'h0000);
        send_beat(KIND_DRAW, 16'hc000);
        drain();
        // size change mid-run waits for the next start
        reg_write(REG_PERM_SIZE, 32'd5);
        send_beat(KIND_START, 16'h0000);
        send_beat(KIND_DRAW, 16'hffff);
        drain();
        reg_write(REG_PERM_SIZE, 32'd2);
        send_beat(KIND_DRAW, 16'h0000);
        send_beat(KIND_DRAW, 16'hffff);
        send_beat(KIND_DRAW, 16'h4000);
        drain();

        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                size_raw = PERM_MAX;
            end
            else if (pick == 1)
            begin
                size_raw = 0;
            end
            else if (pick == 2)
            begin
                size_raw = $urandom_range(PERM_MAX + 1, 127);
            end
            else
            begin
                size_raw = $urandom_range(1, 12);
            end
            run_n = (size_raw == 0) ? 1 : (size_raw > PERM_MAX ? PERM_MAX : size_raw);
            no_gaps = ($urandom_range(0, 3) == 0);
            reg_write(REG_PERM_SIZE, 32'(size_raw));
            // stray draws: carry on a leftover run or get dropped
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4)) send_beat(KIND_DRAW, draw_frac());
            end
            repeat ($urandom_range(1, 3))
            begin
                send_beat(KIND_START, 16'($urandom));
                draws = run_n - 1;
                if ($urandom_range(0, 6) == 0)
                begin
                    draws = $urandom_range(0, draws);
                end
                repeat (draws) send_beat(KIND_DRAW, draw_frac());
                items_sent += 1 + draws;
                if ($urandom_range(0, 5) == 0)
                begin
                    repeat ($urandom_range(1, 2)) send_beat(KIND_DRAW, draw_frac());
                end
            end
            drain();
        end

        if (mismatches == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/crp_pkg.sv
rtl/core/crp_ram.sv
rtl/core/crp_seq.sv
rtl/core/cyclic_random_permutation.sv
tb/sv/crp_tb_pkg.sv
tb/sv/perm_checker.sv
tb/sv/tb.sv
